// ----- hw/rtl/iterated_totient_depth_range_sum_assert.svh -----
// Assertion macros for the iterated totient depth range sum block.
// Used by the top level only; no other dependencies.
`ifndef ITERATED_TOTIENT_DEPTH_RANGE_SUM_ASSERT_SVH
`define ITERATED_TOTIENT_DEPTH_RANGE_SUM_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define ITDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define ITDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/itds_pkg.sv -----
// Shared constants for the iterated totient depth range sum block.
// No dependencies.
package itds_pkg;
    localparam int unsigned TBL_ENTRIES_DEF = 65536;
    localparam int unsigned LIM_W           = 16;
    localparam int unsigned TOT_W           = 16;
    localparam int unsigned SUM_W           = 21;
    localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [LIM_W-1:0] LIM_RESET  = {LIM_W{1'b1}};
endpackage

// ----- hw/rtl/iterated_totient_depth_range_sum.sv -----
// Iterated totient depth range sum: top level.
// Depends on itds_pkg, itds_ram and iterated_totient_depth_range_sum_assert.svh.
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one query item: range_low, range_high.
//  - Output channel (o_out_valid / i_out_ready) returns depth_sum and status per item.
//  - i_cfg_we / i_cfg_data write table_limit (reset 65535); a write forces a rebuild.
//  - The first item after reset or after a limit write builds the tables in memory:
//    an init sweep, the sieve (a read and a check per index, Newton steps for
//    each odd prime's modular inverse, a read, a multiply and a write per multiple
//    update, a step to end each prime's sweep), a depth pass and a prefix pass.
//  - Once built, an item passes from accept through QCHK, QA, QB and OUT to the
//    result register (two prefix reads through the one RAM read port, a subtract,
//    a load); the next item is accepted once the block is back in idle. Bad ranges
//    skip the reads and go from QCHK straight to OUT.
//  - One item is worked at a time; the next is accepted as soon as the result
//    is loaded, even while the receiver still holds it off.
//  - A stalled receiver holds the result register; work finished behind it waits.
//  - Reset (synchronous, active low) clears control state and the built flag.
//    Memory contents are left as they are; the next build rewrites them.
module iterated_totient_depth_range_sum
    import itds_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [LIM_W-1:0] i_range_low,
    input  logic [LIM_W-1:0] i_range_high,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [SUM_W-1:0] o_depth_sum,
    output logic             o_status
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned TW = TOT_W + 1;  // composite mark on top of totient

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_INIT  = 5'd1;
    localparam logic [4:0] ST_SVRD  = 5'd2;
    localparam logic [4:0] ST_SVCHK = 5'd3;
    localparam logic [4:0] ST_INVA  = 5'd4;
    localparam logic [4:0] ST_INVB  = 5'd5;
    localparam logic [4:0] ST_MURD  = 5'd6;
    localparam logic [4:0] ST_MUMUL = 5'd7;
    localparam logic [4:0] ST_MUWR  = 5'd8;
    localparam logic [4:0] ST_DP0   = 5'd9;
    localparam logic [4:0] ST_DP1   = 5'd10;
    localparam logic [4:0] ST_DDRD  = 5'd11;
    localparam logic [4:0] ST_DDT   = 5'd12;
    localparam logic [4:0] ST_DDW   = 5'd13;
    localparam logic [4:0] ST_PFRD  = 5'd14;
    localparam logic [4:0] ST_PFW   = 5'd15;
    localparam logic [4:0] ST_QCHK  = 5'd16;
    localparam logic [4:0] ST_QA    = 5'd17;
    localparam logic [4:0] ST_QB    = 5'd18;
    localparam logic [4:0] ST_OUT   = 5'd19;

    // Control state
    logic [4:0]       r_state, n_state;
    logic             r_built, n_built;
    logic [LIM_W-1:0] r_cfg_limit;
    logic             r_ov, n_ov;
    // Working registers
    logic [AW-1:0]    r_lim, n_lim;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_j, n_j;
    logic [1:0]       r_k, n_k;
    logic [TOT_W-1:0] r_x, n_x;
    logic [TOT_W-1:0] r_t, n_t;
    logic [TOT_W-1:0] r_q, n_q;
    logic [TOT_W-1:0] r_tv, n_tv;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SUM_W-1:0] r_a, n_a;
    logic [SUM_W-1:0] r_res, n_res;
    logic             r_bad, n_bad;
    logic [LIM_W-1:0] r_lo, n_lo;
    logic [LIM_W-1:0] r_hi, n_hi;
    logic [SUM_W-1:0] r_osum, n_osum;
    logic             r_ostat, n_ostat;

    // Memory ports
    logic             tot_we;
    logic [AW-1:0]    tot_waddr, tot_raddr;
    logic [TW-1:0]    tot_wdata, tot_rdata;
    logic             dp_we;
    logic [AW-1:0]    dp_waddr, dp_raddr;
    logic [SUM_W-1:0] dp_wdata, dp_rdata;

    logic [AW-1:0]    lim_clamp;
    logic [TOT_W-1:0] p_val;
    logic [SUM_W:0]   pf_sum;
    logic             q_bad;

    itds_ram #(.W(TW), .D(TABLE_ENTRIES)) u_tot_ram (
        .i_clk  (i_clk),
        .i_we   (tot_we),
        .i_waddr(tot_waddr),
        .i_wdata(tot_wdata),
        .i_raddr(tot_raddr),
        .o_rdata(tot_rdata)
    );

    itds_ram #(.W(SUM_W), .D(TABLE_ENTRIES)) u_dp_ram (
        .i_clk  (i_clk),
        .i_we   (dp_we),
        .i_waddr(dp_waddr),
        .i_wdata(dp_wdata),
        .i_raddr(dp_raddr),
        .o_rdata(dp_rdata)
    );

    assign lim_clamp = (32'(r_cfg_limit) > 32'(TABLE_ENTRIES - 1)) ?
                       AW'(TABLE_ENTRIES - 1) : AW'(r_cfg_limit);
    assign p_val  = TOT_W'(r_i);
    assign pf_sum = {1'b0, r_sum} + {1'b0, dp_rdata};
    assign q_bad  = (r_lo == '0) || (r_lo > r_hi) || (32'(r_hi) > 32'(r_lim));

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_depth_sum = r_osum;
    assign o_status    = r_ostat;

    always_comb begin
        n_state = r_state;
        n_built = r_built;
        n_ov    = r_ov;
        n_lim   = r_lim;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_x     = r_x;
        n_t     = r_t;
        n_q     = r_q;
        n_tv    = r_tv;
        n_sum   = r_sum;
        n_a     = r_a;
        n_res   = r_res;
        n_bad   = r_bad;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_osum  = r_osum;
        n_ostat = r_ostat;

        tot_we    = 1'b0;
        tot_waddr = r_i[AW-1:0];
        tot_wdata = {1'b0, TOT_W'(r_i)};
        tot_raddr = r_i[AW-1:0];
        dp_we     = 1'b0;
        dp_waddr  = r_i[AW-1:0];
        dp_wdata  = '0;
        dp_raddr  = r_i[AW-1:0];

        // drop the held result once the receiver takes it
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_lo = i_range_low;
                    n_hi = i_range_high;
                    if (r_built) begin
                        n_state = ST_QCHK;
                    end else begin
                        n_lim   = lim_clamp;
                        n_i     = '0;
                        n_state = ST_INIT;
                    end
                end
            end
            // totient[i] = i, mark clear
            ST_INIT: begin
                tot_we = 1'b1;
                if (r_i == CW'(r_lim)) begin
                    n_i     = CW'(2);
                    n_state = ST_SVRD;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_SVRD: begin
                if (r_i > CW'(r_lim)) begin
                    n_state = ST_DP0;
                end else begin
                    n_state = ST_SVCHK;
                end
            end
            ST_SVCHK: begin
                if (tot_rdata[TOT_W]) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SVRD;
                end else begin
                    // prime: phi(p) = p - 1, then sweep its multiples
                    tot_we    = 1'b1;
                    tot_wdata = {1'b0, p_val - 1'b1};
                    n_j       = {r_i[AW-1:0], 1'b0};
                    n_x       = p_val;
                    n_k       = '0;
                    n_state   = (r_i == CW'(2)) ? ST_MURD : ST_INVA;
                end
            end
            // Newton steps for the inverse of an odd prime mod 2^16
            ST_INVA: begin
                n_t     = TOT_W'(p_val * r_x);
                n_state = ST_INVB;
            end
            ST_INVB: begin
                n_x = TOT_W'(r_x * (TOT_W'(2) - r_t));
                n_k = r_k + 1'b1;
                n_state = (r_k == 2'd3) ? ST_MURD : ST_INVA;
            end
            ST_MURD: begin
                tot_raddr = r_j[AW-1:0];
                if (r_j > CW'(r_lim)) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SVRD;
                end else begin
                    n_state = ST_MUMUL;
                end
            end
            // exact division by p: shift for 2, inverse multiply otherwise
            ST_MUMUL: begin
                n_tv = tot_rdata[TOT_W-1:0];
                n_q  = (r_i == CW'(2)) ? (tot_rdata[TOT_W-1:0] >> 1) :
                       TOT_W'(tot_rdata[TOT_W-1:0] * r_x);
                n_state = ST_MUWR;
            end
            ST_MUWR: begin
                tot_we    = 1'b1;
                tot_waddr = r_j[AW-1:0];
                tot_wdata = {1'b1, r_tv - r_q};
                n_j       = r_j + r_i;
                n_state   = ST_MURD;
            end
            ST_DP0: begin
                dp_we    = 1'b1;
                dp_waddr = '0;
                n_state  = ST_DP1;
            end
            ST_DP1: begin
                dp_we    = 1'b1;
                dp_waddr = AW'(1);
                n_i      = CW'(2);
                n_state  = ST_DDRD;
            end
            ST_DDRD: begin
                if (r_i > CW'(r_lim)) begin
                    n_i     = CW'(2);
                    n_sum   = '0;
                    n_state = ST_PFRD;
                end else begin
                    n_state = ST_DDT;
                end
            end
            // phi(i) < i, so its depth is already in place
            ST_DDT: begin
                dp_raddr = AW'(tot_rdata[TOT_W-1:0]);
                n_state  = ST_DDW;
            end
            ST_DDW: begin
                dp_we    = 1'b1;
                dp_wdata = dp_rdata + 1'b1;
                n_i      = r_i + 1'b1;
                n_state  = ST_DDRD;
            end
            ST_PFRD: begin
                if (r_i > CW'(r_lim)) begin
                    n_built = 1'b1;
                    n_state = ST_QCHK;
                end else begin
                    n_state = ST_PFW;
                end
            end
            ST_PFW: begin
                dp_we    = 1'b1;
                dp_wdata = pf_sum[SUM_W] ? SUM_MAX : pf_sum[SUM_W-1:0];
                n_sum    = dp_wdata;
                n_i      = r_i + 1'b1;
                n_state  = ST_PFRD;
            end
            ST_QCHK: begin
                dp_raddr = AW'(r_hi);
                n_bad    = q_bad;
                n_res    = '0;
                n_state  = q_bad ? ST_OUT : ST_QA;
            end
            ST_QA: begin
                dp_raddr = AW'(r_lo - 1'b1);
                n_a      = dp_rdata;
                n_state  = ST_QB;
            end
            ST_QB: begin
                n_res   = (r_a >= dp_rdata) ? (r_a - dp_rdata) : '0;
                n_state = ST_OUT;
            end
            // hold here until the result register is free
            ST_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_osum  = r_res;
                    n_ostat = r_bad;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_ov        <= 1'b0;
            r_cfg_limit <= LIM_RESET;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_cfg_limit <= i_cfg_data;
                r_built     <= 1'b0;
            end else begin
                r_built <= n_built;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim   <= n_lim;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_x     <= n_x;
        r_t     <= n_t;
        r_q     <= n_q;
        r_tv    <= n_tv;
        r_sum   <= n_sum;
        r_a     <= n_a;
        r_res   <= n_res;
        r_bad   <= n_bad;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_osum  <= n_osum;
        r_ostat <= n_ostat;
    end

`include "iterated_totient_depth_range_sum_assert.svh"

    `ITDS_ASSERT_NOW(a_query_after_build, i_clk, i_rst_n, (r_state == ST_QCHK), r_built, "query without tables")
    `ITDS_ASSERT_NEXT(a_cfg_clears_built, i_clk, i_rst_n, i_cfg_we, !r_built, "limit write kept tables")
    `ITDS_ASSERT_NOW(a_mult_in_limit, i_clk, i_rst_n, (r_state == ST_MUWR), (r_j <= CW'(r_lim)), "multiple past limit")
    `ITDS_ASSERT_NOW(a_bad_zero_sum, i_clk, i_rst_n, (o_out_valid && o_status), (o_depth_sum == '0), "bad range with sum")

endmodule

// ----- hw/rtl/itds_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module itds_ram #(
    parameter int unsigned W = 16,
    parameter int unsigned D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- tb/iterated_totient_depth_range_sum_tb.sv -----
// Testbench for iterated_totient_depth_range_sum: range queries checked against an
// in-bench totient sieve and depth prefix table. Depends on itds_pkg and the DUT only.
`timescale 1ns / 100ps

module iterated_totient_depth_range_sum_tb;
    import itds_pkg::*;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;
    // Idle cycles without any handshake before giving up; a whole build at the
    // largest limit passes with no handshake at all.
    localparam int unsigned STALL_LIMIT = 4000000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             status;
    } depth_result_t;

    typedef struct {
        logic [LIM_W-1:0] lo;
        logic [LIM_W-1:0] hi;
        bit               typed;
        logic [SUM_W-1:0] sum;
        logic             status;
    } query_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [LIM_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [LIM_W-1:0] i_range_low = '0;
    logic [LIM_W-1:0] i_range_high = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [SUM_W-1:0] o_depth_sum;
    logic             o_status;

    // Typed expectation riding along with the item on the input channel.
    bit               row_typed = 1'b0;
    depth_result_t    row_result = '0;

    iterated_totient_depth_range_sum DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_depth_sum  (o_depth_sum),
        .o_status     (o_status)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: the limit in the register, the limit the tables
    // were built for, and the prefix table of iterated totient depths.
    // ------------------------------------------------------------------
    logic [LIM_W-1:0] limit_reg = LIM_RESET;
    logic [LIM_W-1:0] built_lim = '0;
    bit               tables_ok = 1'b0;
    int unsigned      phi_tab [TBL_ENTRIES_DEF];
    int unsigned      depth_pre [TBL_ENTRIES_DEF];
    bit               is_comp [TBL_ENTRIES_DEF];

    depth_result_t    pending_q[$];
    int unsigned      n_fail = 0;
    int unsigned      n_queries = 0;
    int unsigned      n_results = 0;
    int unsigned      n_good = 0;
    int unsigned      n_builds = 0;
    int unsigned      idle_cycles = 0;
    bit               hold_req = 1'b0;
    bit               hold_done = 1'b0;

    // Sieve phi over 0..lim, then depth per n, then saturating prefix sums.
    function automatic void build_depth_tables(input logic [LIM_W-1:0] lim);
        int unsigned n;
        int unsigned m;
        int unsigned d;
        longint unsigned prod;
        for (n = 0; n <= lim; n++) begin
            is_comp[n] = 1'b0;
            phi_tab[n] = n;
        end
        for (n = 2; n <= lim; n++) begin
            if (is_comp[n]) continue;
            phi_tab[n] = n - 1;
            for (m = 2 * n; m <= lim; m += n) begin
                is_comp[m] = 1'b1;
                prod = longint'(phi_tab[m]) * (n - 1);
                phi_tab[m] = int'(prod / n);
            end
        end
        depth_pre[0] = 0;
        if (lim >= 1) depth_pre[1] = 0;
        for (n = 2; n <= lim; n++) begin
            d = (phi_tab[n] < n) ? depth_pre[phi_tab[n]] + 1 : 1;
            depth_pre[n] = d;
        end
        for (n = 2; n <= lim; n++) begin
            d = depth_pre[n] + depth_pre[n - 1];
            depth_pre[n] = (d > SUM_MAX) ? SUM_MAX : d;
        end
        built_lim = lim;
        tables_ok = 1'b1;
        n_builds++;
    endfunction

    function automatic depth_result_t predict_range_sum(input logic [LIM_W-1:0] lo,
                                                        input logic [LIM_W-1:0] hi);
        depth_result_t r;
        int unsigned a;
        int unsigned b;
        if (!tables_ok) build_depth_tables(limit_reg);
        r = '0;
        if (lo == 0 || lo > hi || hi > built_lim) begin
            r.status = STATUS_BAD;
        end else begin
            a = depth_pre[hi];
            b = depth_pre[lo - 1];
            r.sum = (a >= b) ? SUM_W'(a - b) : '0;
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict at input accept, check at output accept.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        depth_result_t want;
        depth_result_t model;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                model = predict_range_sum(i_range_low, i_range_high);
                if (row_typed && model != row_result) begin
                    $error("predictor disagrees with typed row lo=%0d hi=%0d",
                           i_range_low, i_range_high);
                    n_fail++;
                end
                pending_q.push_back(row_typed ? row_result : model);
                n_queries++;
                if (model.status == STATUS_OK) n_good++;
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_q.size() == 0) begin
                    $error("result with nothing expected: depth_sum=%0d status=%0d",
                           o_depth_sum, o_status);
                    n_fail++;
                end else begin
                    want = pending_q.pop_front();
                    if (o_depth_sum !== want.sum) begin
                        $error("depth_sum: expected %0d, actual %0d", want.sum, o_depth_sum);
                        n_fail++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch stall pattern each time mode_cnt wraps; once, hold off for
    // a long stretch so the block backs up and drops its input ready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int unsigned mode_cnt;
        int unsigned mode;
        int unsigned hold_cnt;
        if (hold_req && !hold_done) begin
            i_out_ready <= 1'b0;
            // count only cycles with a result waiting, so the block backs up behind it
            if (o_out_valid) hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
        end else begin
            if (mode_cnt == 0) mode = $urandom_range(0, 2);
            mode_cnt = (mode_cnt + 1) % 64;
            case (mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender: items go out in bursts; valid stays high across a burst.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_query(input logic [LIM_W-1:0] lo, input logic [LIM_W-1:0] hi,
                              input bit typed, input depth_result_t res);
        int unsigned gap;
        if (burst_left == 0) begin
            // close the burst: drop valid and idle for a random gap, unless it is zero
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid   <= 1'b1;
        i_range_low  <= lo;
        i_range_high <= hi;
        row_typed    <= typed;
        row_result   <= res;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    // Drain every expectation, let the block settle, then write the limit.
    task automatic set_limit(input logic [LIM_W-1:0] lim);
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_reg  = lim;
        tables_ok  = 1'b0;
    endtask

    // Mostly well-formed ranges inside the limit, the rest raw noise.
    task automatic random_queries(input int unsigned count);
        logic [LIM_W-1:0] lo;
        logic [LIM_W-1:0] hi;
        for (int unsigned k = 0; k < count; k++) begin
            if (limit_reg >= 1 && $urandom_range(0, 9) < 8) begin
                lo = LIM_W'($urandom_range(1, limit_reg));
                hi = LIM_W'($urandom_range(lo, limit_reg));
                if ($urandom_range(0, 7) == 0) lo = 1;
                if ($urandom_range(0, 7) == 0) hi = limit_reg;
            end else begin
                lo = LIM_W'($urandom);
                hi = LIM_W'($urandom);
                if ($urandom_range(0, 3) == 0) lo = '0;
            end
            send_query(lo, hi, 1'b0, '0);
        end
    endtask

    // Directed rows: bad ranges, tiny sums and edges, all under limit 20.
    query_row_t directed_rows[] = '{
        '{16'd0,     16'd0,     1'b1, 21'd0, STATUS_BAD},
        '{16'd0,     16'd5,     1'b1, 21'd0, STATUS_BAD},
        '{16'd5,     16'd4,     1'b1, 21'd0, STATUS_BAD},
        '{16'd1,     16'd21,    1'b1, 21'd0, STATUS_BAD},
        '{16'd65535, 16'd65535, 1'b1, 21'd0, STATUS_BAD},
        '{16'd1,     16'd65535, 1'b1, 21'd0, STATUS_BAD},
        '{16'd65535, 16'd1,     1'b1, 21'd0, STATUS_BAD},
        '{16'd1,     16'd1,     1'b1, 21'd0, STATUS_OK},
        '{16'd2,     16'd2,     1'b1, 21'd1, STATUS_OK},
        '{16'd3,     16'd3,     1'b1, 21'd2, STATUS_OK},
        '{16'd1,     16'd3,     1'b1, 21'd3, STATUS_OK},
        '{16'd4,     16'd4,     1'b1, 21'd2, STATUS_OK},
        '{16'd1,     16'd20,    1'b0, 21'd0, STATUS_OK},
        '{16'd20,    16'd20,    1'b0, 21'd0, STATUS_OK},
        '{16'd7,     16'd19,    1'b0, 21'd0, STATUS_OK},
        '{16'd2,     16'd20,    1'b0, 21'd0, STATUS_OK}
    };

    initial begin
        depth_result_t fixed;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Set a small limit before the first query so no full-size build runs yet.
        set_limit(16'd20);
        foreach (directed_rows[r]) begin
            fixed.sum    = directed_rows[r].sum;
            fixed.status = directed_rows[r].status;
            send_query(directed_rows[r].lo, directed_rows[r].hi,
                       directed_rows[r].typed, fixed);
        end
        random_queries(80);

        // Smallest limits: only [1,1] survives at 1, nothing at 0.
        set_limit(16'd2);
        random_queries(60);
        set_limit(16'd1);
        fixed = '{sum: '0, status: STATUS_OK};
        send_query(16'd1, 16'd1, 1'b1, fixed);
        random_queries(30);
        set_limit(16'd0);
        fixed = '{sum: '0, status: STATUS_BAD};
        send_query(16'd1, 16'd1, 1'b1, fixed);
        random_queries(30);

        // Long receiver hold-off while the sender keeps offering items.
        set_limit(16'd300);
        hold_req = 1'b1;
        random_queries(400);

        set_limit(16'd1000);
        random_queries(450);

        // Sender waits for every result before going on.
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait (pending_q.size() == 0);
        random_queries(150);

        // Largest limit: one long build, then wide ranges that reach the top bits.
        set_limit(16'd65535);
        send_query(16'd1, 16'd65535, 1'b0, '0);
        random_queries(60);

        set_limit(16'd4000);
        random_queries(250);
        set_limit(16'd150);
        random_queries(200);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d queries (%0d in range) over %0d table builds; %0d results checked.",
                 n_queries, n_good, n_builds, n_results);
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
